/* rtl/hair_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hair_pkg
// Shared constants, types and table helpers for the Hill rate pipeline.
// ----------------------------------------------------------------------------
package hair_pkg;

   localparam int FracBitsDefault = 16;
   localparam int PowTableDefault = 256;

   localparam int DataW    = 32;
   localparam int ExpW     = 16;
   localparam int HillW    = 17;   // Q1.16 value up to 1.0
   localparam int LogFracW = 16;
   localparam int ExpTabW  = 17;   // Q1.16 value in [1,2)
   localparam int DivBits  = 17;   // quotient bits of the reciprocal
   localparam int NumW     = 49;   // dividend and divisor width
   localparam int HillLat  = 6 + DivBits + 1;

   localparam logic [HillW-1:0] HillOne  = HillW'(65536);
   localparam logic [HillW-1:0] HillHalf = HillW'(32768);

   typedef enum logic [2:0] {
      REG_BASE_PRODUCTION    = 3'd0,
      REG_MAX_PRODUCTION     = 3'd1,
      REG_ACTIVATOR_HALF_SAT = 3'd2,
      REG_ACTIVATOR_HILL_EXP = 3'd3,
      REG_INHIBITOR_HALF_SAT = 3'd4,
      REG_INHIBITOR_HILL_EXP = 3'd5,
      REG_BASE_DECAY         = 3'd6,
      REG_MAX_DECAY          = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic n_zero;
      logic x_zero;
      logic k_zero;
   } hill_flag_type;

   // 16 fraction bits of log2(y), y in [1,2) held as Q2.30
   function automatic logic [LogFracW-1:0] sqlog(input logic [63:0] y_in);
      logic [63:0]         y;
      logic [LogFracW-1:0] r;
      y = y_in;
      r = '0;
      for (int k = 0; k < LogFracW; k++) begin
         y = (y * y) >> 30;
         r = {r[LogFracW-2:0], 1'b0};
         if (y >= 64'h8000_0000) begin
            r[0] = 1'b1;
            y    = y >> 1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/hair_hill.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hair_hill
// Pipelined Hill term x^n / (K^n + x^n) in Q1.16 via log2/exp2 tables and a
// one-bit-per-stage reciprocal divider.
// ----------------------------------------------------------------------------
module hair_hill #(
   parameter int POW_TABLE_ENTRIES = hair_pkg::PowTableDefault
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [hair_pkg::DataW-1:0]  conc,
   input  wire logic [hair_pkg::DataW-1:0]  half_sat,
   input  wire logic [hair_pkg::ExpW-1:0]   hill_exp,
   output logic      [hair_pkg::HillW-1:0]  hill_val
);
   import hair_pkg::*;

   localparam int IdxW = (POW_TABLE_ENTRIES > 1) ? $clog2(POW_TABLE_ENTRIES) : 1;
   localparam int LogW = 5 + LogFracW;
   localparam int QW   = LogW + ExpW - 12;
   localparam int RemW = NumW + DivBits - 1;

   typedef logic [LogFracW-1:0] log_tab_type [POW_TABLE_ENTRIES];
   typedef logic [ExpTabW-1:0]  exp_tab_type [POW_TABLE_ENTRIES];

   function automatic log_tab_type build_log();
      log_tab_type t;
      for (int i = 0; i < POW_TABLE_ENTRIES; i++)
         t[i] = sqlog(64'h4000_0000 + ((64'(i) << 30) / POW_TABLE_ENTRIES));
      return t;
   endfunction

   function automatic exp_tab_type build_exp();
      exp_tab_type t;
      logic [63:0] lo, hi, mid;
      logic [15:0] target;
      for (int i = 0; i < POW_TABLE_ENTRIES; i++) begin
         target = 16'((64'(i) << 16) / POW_TABLE_ENTRIES);
         lo = 64'd65536;
         hi = 64'd131071;
         for (int s = 0; s < 18; s++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (sqlog(mid << 14) >= target)
                  hi = mid;
               else
                  lo = mid + 64'd1;
            end
         end
         t[i] = ExpTabW'(lo);
      end
      return t;
   endfunction

   localparam log_tab_type LOG_TAB = build_log();
   localparam exp_tab_type EXP_TAB = build_exp();

   function automatic logic [4:0] msb_index(input logic [DataW-1:0] v);
      logic [4:0] e;
      e = '0;
      for (int i = 0; i < DataW; i++)
         if (v[i]) e = 5'(i);
      return e;
   endfunction

   function automatic logic [IdxW-1:0] log_index(input logic [DataW-1:0] v,
                                                 input logic [4:0] e);
      logic [DataW-1:0] sh;
      logic [63:0]      p;
      sh = v << (5'd31 - e);
      p  = 64'(sh[30:0]) * 64'(POW_TABLE_ENTRIES);
      return p[31 +: IdxW];
   endfunction

   // stage 1: msb search
   hill_flag_type     f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic [DataW-1:0]  x1_ff, k1_ff;
   logic [4:0]        ex1_ff, ek1_ff, ex2_ff, ek2_ff;
   logic [ExpW-1:0]   n1_ff, n2_ff, n3_ff;
   // stage 2: table index
   logic [IdxW-1:0]   ix2_ff, ik2_ff;
   // stage 3: log values
   logic [LogW-1:0]   lx3_ff, lk3_ff;
   // stage 4: scaled difference
   logic [QW-1:0]     q4_ff;
   logic              neg4_ff, neg5_ff, neg6_ff;
   // stage 5: split
   logic [IdxW-1:0]   ie5_ff;
   logic [4:0]        ip5_ff;
   logic              big5_ff, big6_ff;
   // stage 6 and divider
   logic [NumW-1:0]   den_ff [DivBits+1];
   logic [NumW-1:0]   rem_ff [DivBits+1];
   logic [DivBits-1:0] quo_ff [DivBits+1];
   hill_flag_type     fd_ff  [DivBits+1];
   logic              negd_ff[DivBits+1];
   logic              bigd_ff[DivBits+1];
   logic [HillW-1:0]  hill_ff;

   logic [LogW-1:0]   mag4_in;
   logic [LogW+ExpW-1:0] prod4_in;
   logic [31:0]       fp5_in;
   logic [NumW-1:0]   e6_in, den6_in;

   always_comb begin
      mag4_in  = (lk3_ff >= lx3_ff) ? lk3_ff - lx3_ff : lx3_ff - lk3_ff;
      prod4_in = (LogW+ExpW)'(mag4_in) * (LogW+ExpW)'(n3_ff);
      fp5_in   = 32'(q4_ff[15:0]) * 32'(POW_TABLE_ENTRIES);
      e6_in    = NumW'(EXP_TAB[ie5_ff]) << ip5_ff;
      den6_in  = NumW'(65536) + e6_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff  <= conc;
         k1_ff  <= half_sat;
         n1_ff  <= hill_exp;
         ex1_ff <= msb_index(conc);
         ek1_ff <= msb_index(half_sat);
         f1_ff  <= '{n_zero: (hill_exp == '0), x_zero: (conc == '0),
                     k_zero: (half_sat == '0)};

         ix2_ff <= log_index(x1_ff, ex1_ff);
         ik2_ff <= log_index(k1_ff, ek1_ff);
         ex2_ff <= ex1_ff;
         ek2_ff <= ek1_ff;
         n2_ff  <= n1_ff;
         f2_ff  <= f1_ff;

         lx3_ff <= {ex2_ff, LOG_TAB[ix2_ff]};
         lk3_ff <= {ek2_ff, LOG_TAB[ik2_ff]};
         n3_ff  <= n2_ff;
         f3_ff  <= f2_ff;

         q4_ff   <= prod4_in[12 +: QW];
         neg4_ff <= (lk3_ff < lx3_ff);
         f4_ff   <= f3_ff;

         ie5_ff  <= fp5_in[16 +: IdxW];
         ip5_ff  <= q4_ff[20:16];
         big5_ff <= |q4_ff[QW-1:21];
         neg5_ff <= neg4_ff;
         f5_ff   <= f4_ff;

         den_ff[0]  <= den6_in;
         rem_ff[0]  <= NumW'(64'h1_0000_0000) + (den6_in >> 1);
         quo_ff[0]  <= '0;
         fd_ff[0]   <= f5_ff;
         negd_ff[0] <= neg5_ff;
         bigd_ff[0] <= big5_ff;
         f6_ff      <= f5_ff;
         neg6_ff    <= neg5_ff;
         big6_ff    <= big5_ff;

         for (int s = 0; s < DivBits; s++) begin
            if (RemW'(rem_ff[s]) >= (RemW'(den_ff[s]) << (DivBits - 1 - s))) begin
               rem_ff[s+1] <= NumW'(RemW'(rem_ff[s]) -
                                    (RemW'(den_ff[s]) << (DivBits - 1 - s)));
               quo_ff[s+1] <= quo_ff[s] | (DivBits'(1) << (DivBits - 1 - s));
            end else begin
               rem_ff[s+1] <= rem_ff[s];
               quo_ff[s+1] <= quo_ff[s];
            end
            den_ff[s+1]  <= den_ff[s];
            fd_ff[s+1]   <= fd_ff[s];
            negd_ff[s+1] <= negd_ff[s];
            bigd_ff[s+1] <= bigd_ff[s];
         end

         priority if (fd_ff[DivBits].n_zero)
            hill_ff <= HillHalf;
         else if (fd_ff[DivBits].x_zero)
            hill_ff <= '0;
         else if (fd_ff[DivBits].k_zero)
            hill_ff <= HillOne;
         else if (bigd_ff[DivBits])
            hill_ff <= negd_ff[DivBits] ? HillOne : '0;
         else if (negd_ff[DivBits])
            hill_ff <= HillOne - HillW'(quo_ff[DivBits]);
         else
            hill_ff <= HillW'(quo_ff[DivBits]);
      end
   end

   assign hill_val = hill_ff;

   // f6_ff, neg6_ff and big6_ff mirror the divider entry for checks
   always_ff @(posedge clock) begin
      if (en && f6_ff.n_zero && !fd_ff[0].n_zero)
         $error("hill flags diverged at divider entry");
      if (en && (neg6_ff != negd_ff[0] || big6_ff != bigd_ff[0]))
         $error("hill sign or range flag diverged at divider entry");
   end

endmodule

`default_nettype wire

/* rtl/hill_activator_inhibitor_rate.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hill_activator_inhibitor_rate
// Per-particle activator flux update with Hill production and decay terms.
// ----------------------------------------------------------------------------
// One item enters per clock whenever the result side is not stalled. Each
// item returns one result; the path depth is set by the two Hill units
// whose reciprocal divider resolves one quotient bit per stage. The whole
// pipeline holds as one on a result stall.
module hill_activator_inhibitor_rate #(
   parameter int FRAC_BITS         = hair_pkg::FracBitsDefault,
   parameter int POW_TABLE_ENTRIES = hair_pkg::PowTableDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // activator_conc, inhibitor_conc, flux_in
   input  wire logic [95:0] req_tdata,
   input  wire logic [0:0]  req_tuser,  // in_group
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // flux_out, saturated, zero pad
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);
   import hair_pkg::*;

   localparam int NSt  = HillLat + 4;
   localparam int MulW = 2 * DataW + 1;

   typedef struct packed {
      logic [DataW-1:0] a;
      logic [DataW-1:0] flux;
      logic             grp;
      logic             last;
   } side_type;

   logic [DataW-1:0] base_prod_ff, max_prod_ff, act_ks_ff, inh_ks_ff;
   logic [DataW-1:0] base_dec_ff, max_dec_ff;
   logic [ExpW-1:0]  act_n_ff, inh_n_ff;

   logic             en;
   logic             t0_vld_ff;
   logic [DataW-1:0] t0_b_ff;
   side_type         t0_sd_ff;
   logic             vld_ff [NSt];
   side_type         sd_ff  [NSt];
   logic [HillW-1:0] ha, hb;

   logic [DataW+HillW-1:0] pm1_ff, mm1_ff;
   logic [DataW:0]         prod2_ff, mu2_ff, prod3_ff, prod4_ff;
   logic [MulW-1:0]        hi3_ff, lo3_ff;
   logic [MulW:0]          dec4_ff;
   logic signed [MulW+1:0] t_in;
   logic [DataW-1:0]       flux_in;
   logic                   sat_in;

   logic             rsp_vld_ff, rsp_last_ff, rsp_sat_ff;
   logic [DataW-1:0] rsp_flux_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_prod_ff <= '0;
         max_prod_ff  <= DataW'(65536);
         act_ks_ff    <= DataW'(65536);
         act_n_ff     <= ExpW'(4096);
         inh_ks_ff    <= DataW'(65536);
         inh_n_ff     <= ExpW'(4096);
         base_dec_ff  <= '0;
         max_dec_ff   <= DataW'(65536);
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            REG_BASE_PRODUCTION:    base_prod_ff <= csr_wdata;
            REG_MAX_PRODUCTION:     max_prod_ff  <= csr_wdata;
            REG_ACTIVATOR_HALF_SAT: act_ks_ff    <= csr_wdata;
            REG_ACTIVATOR_HILL_EXP: act_n_ff     <= csr_wdata[ExpW-1:0];
            REG_INHIBITOR_HALF_SAT: inh_ks_ff    <= csr_wdata;
            REG_INHIBITOR_HILL_EXP: inh_n_ff     <= csr_wdata[ExpW-1:0];
            REG_BASE_DECAY:         base_dec_ff  <= csr_wdata;
            REG_MAX_DECAY:          max_dec_ff   <= csr_wdata;
            default:                base_prod_ff <= base_prod_ff;
         endcase
      end
   end

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   hair_hill #(.POW_TABLE_ENTRIES(POW_TABLE_ENTRIES)) u_hill_act (
      .clock    (clock),
      .en       (en),
      .conc     (t0_sd_ff.a),
      .half_sat (act_ks_ff),
      .hill_exp (act_n_ff),
      .hill_val (ha)
   );

   hair_hill #(.POW_TABLE_ENTRIES(POW_TABLE_ENTRIES)) u_hill_inh (
      .clock    (clock),
      .en       (en),
      .conc     (t0_b_ff),
      .half_sat (inh_ks_ff),
      .hill_exp (inh_n_ff),
      .hill_val (hb)
   );

   always_comb begin
      t_in = $signed({{(MulW+2-DataW){sd_ff[NSt-1].flux[DataW-1]}}, sd_ff[NSt-1].flux})
           + $signed((MulW+2)'(prod4_ff))
           - $signed((MulW+2)'(dec4_ff));
      sat_in  = 1'b0;
      flux_in = t_in[DataW-1:0];
      priority if (!sd_ff[NSt-1].grp) begin
         flux_in = sd_ff[NSt-1].flux;
      end else if (t_in > $signed((MulW+2)'(32'h7FFF_FFFF))) begin
         flux_in = 32'h7FFF_FFFF;
         sat_in  = 1'b1;
      end else if (t_in < -$signed((MulW+2)'(33'h0_8000_0000))) begin
         flux_in = 32'h8000_0000;
         sat_in  = 1'b1;
      end else begin
         flux_in = t_in[DataW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < NSt; i++)
            vld_ff[i] <= 1'b0;
      end else if (en) begin
         t0_vld_ff  <= req_tvalid;
         vld_ff[0]  <= t0_vld_ff;
         for (int i = 1; i < NSt; i++)
            vld_ff[i] <= vld_ff[i-1];
         rsp_vld_ff <= vld_ff[NSt-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_sd_ff <= '{a: req_tdata[31:0], flux: req_tdata[95:64],
                       grp: req_tuser[0], last: req_tlast};
         t0_b_ff  <= req_tdata[63:32];
         sd_ff[0] <= t0_sd_ff;
         for (int i = 1; i < NSt; i++)
            sd_ff[i] <= sd_ff[i-1];

         pm1_ff <= (DataW+HillW)'(max_prod_ff) * (DataW+HillW)'(ha);
         mm1_ff <= (DataW+HillW)'(max_dec_ff) * (DataW+HillW)'(hb);

         prod2_ff <= (DataW+1)'(base_prod_ff) + (DataW+1)'(pm1_ff[DataW+HillW-1:16]);
         mu2_ff   <= (DataW+1)'(base_dec_ff) + (DataW+1)'(mm1_ff[DataW+HillW-1:16]);

         hi3_ff   <= MulW'(mu2_ff) * MulW'(sd_ff[HillLat+1].a >> FRAC_BITS);
         lo3_ff   <= MulW'(mu2_ff) *
                     MulW'(sd_ff[HillLat+1].a & ((DataW'(1) << FRAC_BITS) - DataW'(1)));
         prod3_ff <= prod2_ff;

         dec4_ff  <= (MulW+1)'(hi3_ff) + (MulW+1)'(lo3_ff >> FRAC_BITS);
         prod4_ff <= prod3_ff;

         rsp_flux_ff <= flux_in;
         rsp_sat_ff  <= sat_in;
         rsp_last_ff <= sd_ff[NSt-1].last;
      end
   end

   assign rsp_tdata  = {7'd0, rsp_sat_ff, rsp_flux_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_vld_ff;

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_sat_ff |->
         rsp_flux_ff == 32'h7FFF_FFFF || rsp_flux_ff == 32'h8000_0000)
      else $error("saturated result not at a limit");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && !t0_vld_ff)
      else $error("pipeline holds items after reset");

   a_hill_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[HillLat-1] |-> ha <= HillOne && hb <= HillOne)
      else $error("Hill term above one");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff[NSt-1]) && $stable(prod4_ff))
      else $error("pipeline advanced during stall");

endmodule

`default_nettype wire
